// ===== rtl/lru_key_value_cache_assert.svh =====
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// check that is disabled while reset is asserted
`define LKVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check that also holds during reset
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`else

`define LKVC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, derived widths and the request/response bundle of the recency list.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_BITS   = 14;
    localparam int ENTRIES    = 16;
    localparam int VALUE_BITS = 32;

    localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);
    localparam int CAP_BITS  = 5;
    localparam int EFF_BITS  = (CAP_BITS > OCC_BITS) ? CAP_BITS : OCC_BITS;

    localparam int MAP_DEPTH = 2 ** KEY_BITS;
    localparam int MAP_BITS  = SLOT_BITS + 1;   // {valid, slot}

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [SLOT_BITS-1:0]  t_slot;

    // one item's recency update, issued once the key map has been read
    typedef struct packed {
        logic                valid;
        logic                hit;
        logic                put;
        t_slot               slot;      // slot from the key map, meaningful on hit
        logic [CAP_BITS-1:0] capacity;
    } t_lru_req;

    typedef struct packed {
        t_slot slot;    // slot the item works on
        logic  evict;   // least recent entry is replaced
    } t_lru_rsp;

endpackage

// ===== rtl/lkvc_lru.sv =====
// ----------------------------------------------------------------------------
// LRU recency list
// Doubly linked slot list, head/tail pointers and occupancy; picks the slot.
// ----------------------------------------------------------------------------
module lkvc_lru (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lkvc_pkg::t_lru_req i_req,
    output lkvc_pkg::t_lru_rsp o_rsp
);

`include "lru_key_value_cache_assert.svh"

    lkvc_pkg::t_slot r_newer [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_slot r_older [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_slot r_mru;
    lkvc_pkg::t_slot r_lru;
    logic [lkvc_pkg::OCC_BITS-1:0] r_occ;

    logic [lkvc_pkg::EFF_BITS-1:0] cap_ext;
    logic [lkvc_pkg::EFF_BITS-1:0] eff_cap;
    logic                          full;
    logic                          cnt_zero;
    lkvc_pkg::t_slot               slot;
    lkvc_pkg::t_slot               nw;
    lkvc_pkg::t_slot               od;

    always_comb begin
        cap_ext = lkvc_pkg::EFF_BITS'(i_req.capacity);
        if (cap_ext == '0) begin
            eff_cap = lkvc_pkg::EFF_BITS'(1);
        end else if (cap_ext > lkvc_pkg::EFF_BITS'(lkvc_pkg::ENTRIES)) begin
            eff_cap = lkvc_pkg::EFF_BITS'(lkvc_pkg::ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = (lkvc_pkg::EFF_BITS'(r_occ) >= eff_cap) && (r_occ != '0);

        if (i_req.hit) begin
            slot = i_req.slot;
        end else if (full) begin
            slot = r_lru;
        end else begin
            slot = r_occ[lkvc_pkg::SLOT_BITS-1:0];
        end

        nw = r_newer[slot];
        od = r_older[slot];
        // list is empty after an eviction, before the new slot is linked
        cnt_zero = full ? (r_occ == lkvc_pkg::OCC_BITS'(1)) : (r_occ == '0);
    end

    assign o_rsp.slot  = slot;
    assign o_rsp.evict = !i_req.hit && i_req.put && full;

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mru <= '0;
            r_lru <= '0;
            r_occ <= '0;
        end else if (i_req.valid) begin
            if (i_req.hit) begin
                if (slot != r_mru) begin
                    if (slot == r_lru) begin
                        r_lru <= nw;
                    end
                    r_mru <= slot;
                end
            end else if (i_req.put) begin
                r_mru <= slot;
                if (cnt_zero) begin
                    r_lru <= slot;
                end else if (full) begin
                    r_lru <= nw;
                end
                if (!full) begin
                    r_occ <= r_occ + 1'b1;
                end
            end
        end
    end

    // link arrays: no reset, an entry is read only after it is written
    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            if (i_req.hit) begin
                if (slot != r_mru) begin
                    if (slot != r_lru) begin
                        r_newer[od] <= nw;
                        r_older[nw] <= od;
                    end
                    r_older[slot]  <= r_mru;
                    r_newer[r_mru] <= slot;
                end
            end else if (i_req.put && !cnt_zero) begin
                r_older[slot]  <= r_mru;
                r_newer[r_mru] <= slot;
            end
        end
    end

    `LKVC_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= lkvc_pkg::OCC_BITS'(lkvc_pkg::ENTRIES), "occupancy above entry count")
    `LKVC_ASSERT(a_evict_nonempty, i_clk, i_rst_n, i_req.valid && o_rsp.evict |-> r_occ != '0, "eviction from empty list")
    `LKVC_ASSERT(a_mru_follows, i_clk, i_rst_n, i_req.valid && (i_req.hit || i_req.put) |=> r_mru == $past(o_rsp.slot), "touched slot is not most recent")

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache
// Get/put store with least-recently-used replacement over a key map memory.
// ----------------------------------------------------------------------------
// Items are worked one at a time through the key map read, slot read and
// write back steps; the result is registered in the write-back step, and
//   an item waits in the last step only while the previous result is stalled.
// Reset: synchronous, active low. Afterwards the key map is swept clear,
//   one key per cycle over all 16384 keys, with o_in_stall high; config writes
//   are taken throughout.
module lru_key_value_cache (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration: capacity register
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lkvc_pkg::CAP_BITS-1:0]       i_cfg_capacity,
    // item channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [lkvc_pkg::KEY_BITS-1:0]       i_key,
    input  logic [lkvc_pkg::VALUE_BITS-1:0]     i_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic [lkvc_pkg::VALUE_BITS-1:0]     o_read_value,
    output logic                                o_evicted,
    output logic [lkvc_pkg::KEY_BITS-1:0]       o_evicted_key
);

`include "lru_key_value_cache_assert.svh"

    localparam int SLOT_W = lkvc_pkg::KEY_BITS + lkvc_pkg::VALUE_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,   // post-reset sweep of the key map
        ST_IDLE,    // take an item beat, start the key map read
        ST_LOOK,    // key map data back: pick slot, update recency, read slot
        ST_DATA     // slot data back: emit result, write back
    } t_state;

    t_state r_state;

    // capacity register
    logic [lkvc_pkg::CAP_BITS-1:0] r_capacity;

    // item being worked on
    logic            r_action;
    lkvc_pkg::t_key  r_key;
    lkvc_pkg::t_value r_value;
    lkvc_pkg::t_slot r_slot;
    logic            r_hit;
    logic            r_evict;

    logic [lkvc_pkg::KEY_BITS-1:0] r_clr_addr;

    // memories: key map {valid, slot} and slot contents {key, value}
    logic [lkvc_pkg::MAP_BITS-1:0] map_mem  [lkvc_pkg::MAP_DEPTH];
    logic [SLOT_W-1:0]             slot_mem [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::MAP_BITS-1:0] r_map_rdata;
    logic [SLOT_W-1:0]             r_slot_rdata;

    // output register
    logic                    r_out_valid;
    logic                    r_o_hit;
    lkvc_pkg::t_value        r_o_read_value;
    logic                    r_o_evicted;
    lkvc_pkg::t_key          r_o_evicted_key;

    logic                          in_acc;
    logic                          out_free;
    logic                          data_done;
    logic                          map_we;
    logic [lkvc_pkg::KEY_BITS-1:0] map_waddr;
    logic [lkvc_pkg::MAP_BITS-1:0] map_wdata;
    lkvc_pkg::t_key                slot_rkey;
    lkvc_pkg::t_value              slot_rvalue;

    lkvc_pkg::t_lru_req lru_req;
    lkvc_pkg::t_lru_rsp lru_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    // output register can take a new result this cycle
    assign out_free    = !r_out_valid || !i_out_stall;
    assign data_done   = (r_state == ST_DATA) && out_free;

    assign slot_rkey   = r_slot_rdata[SLOT_W-1 -: lkvc_pkg::KEY_BITS];
    assign slot_rvalue = r_slot_rdata[lkvc_pkg::VALUE_BITS-1:0];

    // recency list works while the key map data is on hand
    always_comb begin
        lru_req.valid    = (r_state == ST_LOOK);
        lru_req.hit      = r_map_rdata[lkvc_pkg::SLOT_BITS];
        lru_req.put      = r_action;
        lru_req.slot     = r_map_rdata[lkvc_pkg::SLOT_BITS-1:0];
        lru_req.capacity = r_capacity;
    end

    lkvc_lru u_lru (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lru_req),
        .o_rsp   (lru_rsp)
    );

    // key map write port: sweep, new-key insert, evicted-key removal.
    // Insert and removal never name the same key (the new key was absent).
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_key;
        map_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr_addr;
            end
            ST_LOOK: begin
                map_we    = r_action && !r_map_rdata[lkvc_pkg::SLOT_BITS];
                map_wdata = {1'b1, lru_rsp.slot};
            end
            ST_DATA: begin
                map_we    = data_done && r_evict;
                map_waddr = slot_rkey;
            end
            default: begin
                map_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (in_acc) begin
            r_map_rdata <= map_mem[i_key];
        end
    end

    // slot store: read once per item, written back by a put
    always_ff @(posedge i_clk) begin
        if (data_done && r_action) begin
            slot_mem[r_slot] <= {r_key, r_value};
        end
        if (r_state == ST_LOOK) begin
            r_slot_rdata <= slot_mem[lru_rsp.slot];
        end
    end

    // item payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_value  <= i_value;
        end
        if (r_state == ST_LOOK) begin
            r_slot  <= lru_rsp.slot;
            r_hit   <= r_map_rdata[lkvc_pkg::SLOT_BITS];
            r_evict <= lru_rsp.evict;
        end
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_capacity  <= lkvc_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_capacity;
            end
            // a new result loads the register, else a taken beat empties it
            if (data_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    r_state <= ST_DATA;
                end
                ST_DATA: begin
                    if (out_free) begin
                        r_o_hit         <= r_hit;
                        r_o_read_value  <= (r_hit && !r_action) ? slot_rvalue : '0;
                        r_o_evicted     <= r_evict;
                        r_o_evicted_key <= r_evict ? slot_rkey : '0;
                        r_state         <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_read_value;
    assign o_evicted     = r_o_evicted;
    assign o_evicted_key = r_o_evicted_key;

    `LKVC_ASSERT(a_result_from_data, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_DATA), "result loaded outside write-back step")
    `LKVC_ASSERT(a_evict_not_hit, i_clk, i_rst_n, o_out_valid && o_evicted |-> !o_hit, "eviction reported on a hit")
    `LKVC_ASSERT(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_hit |-> o_read_value == '0, "value returned on a miss")
    `LKVC_ASSERT(a_evict_full, i_clk, i_rst_n, (r_state == ST_LOOK) && lru_rsp.evict |-> r_action && !r_map_rdata[lkvc_pkg::SLOT_BITS], "eviction without a put miss")

endmodule

// ===== test/lru_key_value_cache_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get/put beats through the item channel under random idle and stall
// patterns, mirrors the recency list in a scoreboard class, and compares every
// result beat field by field. The capacity register is stepped through its
// extremes and through values below the current occupancy.
// ----------------------------------------------------------------------------

typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
} t_action;

typedef struct packed {
    logic             hit;
    lkvc_pkg::t_value read_value;
    logic             evicted;
    lkvc_pkg::t_key   evicted_key;
} t_reply;

// Shadow copy of the cache: key map, slot contents and the recency list.
class lru_mirror;
    bit                            map_valid [lkvc_pkg::MAP_DEPTH];
    lkvc_pkg::t_slot               map_slot  [lkvc_pkg::MAP_DEPTH];
    lkvc_pkg::t_key                slot_key  [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_value              slot_val  [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_slot               newer     [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_slot               older     [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_slot               mru;
    lkvc_pkg::t_slot               lru;
    int unsigned                   occ;
    logic [lkvc_pkg::CAP_BITS-1:0] capacity;
    t_reply                        owed_replies[$];
    int unsigned                   mismatches;
    int unsigned                   requests;
    int unsigned                   hits;
    int unsigned                   evictions;

    function new();
        mru        = '0;
        lru        = '0;
        occ        = 0;
        capacity   = lkvc_pkg::CAP_RESET;
        mismatches = 0;
        requests   = 0;
        hits       = 0;
        evictions  = 0;
    endfunction

    function void set_capacity(logic [lkvc_pkg::CAP_BITS-1:0] c);
        capacity = c;
    endfunction

    function void note_request(t_action act, lkvc_pkg::t_key k, lkvc_pkg::t_value v);
        t_reply          r;
        lkvc_pkg::t_slot s;
        lkvc_pkg::t_slot nw;
        lkvc_pkg::t_slot od;
        int unsigned     eff;
        r   = '0;
        eff = (capacity == 0) ? 1 :
              ((capacity > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : capacity);
        if (map_valid[k]) begin
            r.hit = 1'b1;
            s     = map_slot[k];
            if (act == ACT_PUT) begin
                slot_val[s] = v;
            end else begin
                r.read_value = slot_val[s];
            end
            // unlink and move to the most recent end
            if (s != mru) begin
                nw = newer[s];
                if (s == lru) begin
                    lru = nw;
                end else begin
                    od        = older[s];
                    newer[od] = nw;
                    older[nw] = od;
                end
                older[s]   = mru;
                newer[mru] = s;
                mru        = s;
            end
        end else if (act == ACT_PUT) begin
            if (occ >= eff && occ > 0) begin
                s                     = lru;
                r.evicted             = 1'b1;
                r.evicted_key         = slot_key[s];
                map_valid[slot_key[s]] = 1'b0;
                if (occ > 1) begin
                    lru = newer[s];
                end
                occ--;
            end else begin
                s = lkvc_pkg::t_slot'(occ);
            end
            slot_key[s]  = k;
            slot_val[s]  = v;
            map_valid[k] = 1'b1;
            map_slot[k]  = s;
            if (occ == 0) begin
                mru = s;
                lru = s;
            end else begin
                older[s]   = mru;
                newer[mru] = s;
                mru        = s;
            end
            occ++;
        end
        requests++;
        if (r.hit) hits++;
        if (r.evicted) evictions++;
        owed_replies.push_back(r);
    endfunction

    function void check_reply(t_reply got);
        t_reply want;
        if (owed_replies.size() == 0) begin
            $display("%0t: result beat with nothing outstanding: hit=%0b read_value=%h evicted=%0b evicted_key=%h",
                     $time, got.hit, got.read_value, got.evicted, got.evicted_key);
            mismatches++;
        end else begin
            want = owed_replies.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                mismatches++;
            end
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
            if (got.evicted !== want.evicted) begin
                $display("%0t: evicted expected %0b actual %0b",
                         $time, want.evicted, got.evicted);
                mismatches++;
            end
            if (got.evicted_key !== want.evicted_key) begin
                $display("%0t: evicted_key expected %h actual %h",
                         $time, want.evicted_key, got.evicted_key);
                mismatches++;
            end
        end
    endfunction
endclass

module lru_key_value_cache_test;

    localparam int SEGMENTS      = 9;
    localparam int SEG_ITEMS     = 92;
    localparam int SETTLE_CYCLES = 12;       // slack after the last result
    localparam int CYCLE_LIMIT   = 600_000;  // includes the post-reset map sweep

    localparam logic [lkvc_pkg::CAP_BITS-1:0] SEG_CAPACITY [SEGMENTS] =
        '{5'd2, 5'd0, 5'd31, 5'd5, 5'd1, 5'd17, 5'd16, 5'd8, 5'd3};

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [lkvc_pkg::CAP_BITS-1:0] i_cfg_capacity;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_action;
    lkvc_pkg::t_key                i_key;
    lkvc_pkg::t_value              i_value;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_hit;
    lkvc_pkg::t_value              o_read_value;
    logic                          o_evicted;
    lkvc_pkg::t_key                o_evicted_key;

    lru_mirror      ledger;
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    cycle_count    = 0;
    lkvc_pkg::t_key key_pool [32];
    int unsigned    pool_size      = 8;

    lru_key_value_cache u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_read_value   (o_read_value),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            ledger.check_reply({o_hit, o_read_value, o_evicted, o_evicted_key});
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, ledger.owed_replies.size());
            $display("** lru_key_value_cache: FAILED **");
            $finish;
        end
    end

    // One item beat; valid stays high into the next call unless it idles.
    task automatic send_item(input t_action act, input lkvc_pkg::t_key k,
                             input lkvc_pkg::t_value v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key      <= k;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        ledger.note_request(act, k, v);
    endtask

    // drop valid and hold off until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (ledger.owed_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lkvc_pkg::CAP_BITS-1:0] c);
        @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= c;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.set_capacity(c);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic lkvc_pkg::t_key pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, pool_size - 1)];
        end
        return lkvc_pkg::t_key'($urandom_range(0, lkvc_pkg::MAP_DEPTH - 1));
    endfunction

    initial begin : stimulus
        int          seg;
        int          n;
        int unsigned eff;
        ledger         = new();
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_capacity = lkvc_pkg::CAP_RESET;
        i_in_valid     = 1'b0;
        i_action       = ACT_GET;
        i_key          = '0;
        i_value        = '0;
        for (n = 0; n < 32; n++) begin
            key_pool[n] = lkvc_pkg::t_key'($urandom_range(0, lkvc_pkg::MAP_DEPTH - 1));
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two-entry cache, hits, misses, updates, evictions
        write_capacity(5'd2);
        send_item(ACT_GET, 14'h0000, 32'hFFFF_FFFF);   // miss on empty cache
        send_item(ACT_PUT, 14'h0000, 32'h0000_0000);
        send_item(ACT_PUT, 14'h3FFF, 32'hFFFF_FFFF);
        send_item(ACT_GET, 14'h0000, 32'h0);          // hit, key 0 becomes newest
        send_item(ACT_PUT, 14'h1555, 32'hA5A5_A5A5);   // evicts the all-ones key
        send_item(ACT_GET, 14'h3FFF, 32'h0);          // miss after eviction
        send_item(ACT_PUT, 14'h0000, 32'h1234_5678);   // update in place
        send_item(ACT_GET, 14'h0000, 32'h0);
        send_item(ACT_PUT, 14'h2AAA, 32'h5A5A_5A5A);   // evicts 0x1555
        send_item(ACT_GET, 14'h1555, 32'h0);

        // zero acts as one, and sits below the current occupancy of two
        wait_drained();
        write_capacity(5'd0);
        send_item(ACT_PUT, 14'h1000, 32'hDEAD_BEEF);
        send_item(ACT_GET, 14'h2AAA, 32'h0);
        send_item(ACT_PUT, 14'h0FFF, 32'hCAFE_F00D);
        send_item(ACT_GET, 14'h1000, 32'h0);
        send_item(ACT_PUT, 14'h0FFF, 32'h0BAD_F00D);

        // above the slot count acts as the full size
        wait_drained();
        write_capacity(5'd31);
        for (n = 0; n < 6; n++) send_item(ACT_PUT, lkvc_pkg::t_key'(14'h0100 + n), $urandom);
        send_item(ACT_GET, 14'h0103, 32'h0);

        // random segments; idle pattern moves from slow receiver to slow
        // sender to none
        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            write_capacity(SEG_CAPACITY[seg]);
            if (seg < 3) begin
                send_idle_pct  = 10;
                recv_stall_pct = 85;
            end else if (seg < 6) begin
                send_idle_pct  = 85;
                recv_stall_pct = 10;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // keep a few old keys so lookups span capacity changes
            for (n = 8; n < 32; n++) begin
                key_pool[n] = lkvc_pkg::t_key'($urandom_range(0, lkvc_pkg::MAP_DEPTH - 1));
            end
            eff = (SEG_CAPACITY[seg] == 0) ? 1 :
                  ((SEG_CAPACITY[seg] > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES :
                   SEG_CAPACITY[seg]);
            pool_size = eff + 4;
            for (n = 0; n < SEG_ITEMS; n++) begin
                if (n == SEG_ITEMS / 2) wait_drained();
                send_item(t_action'($urandom_range(0, 1)), pick_key(), $urandom);
            end
        end

        wait_drained();
        $display("%0d requests over %0d capacity settings: %0d hits, %0d evictions",
                 ledger.requests, SEGMENTS + 3, ledger.hits, ledger.evictions);
        $display("idle mixes: slow receiver, slow sender, back to back; %0d mismatches",
                 ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.owed_replies.size() == 0) begin
            $display("** lru_key_value_cache: PASSED **");
        end else begin
            $display("** lru_key_value_cache: FAILED **");
        end
        $finish;
    end

endmodule
